FILE: rtl/ah_pkg.sv
package ah_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int SLOPE_FRAC = 12;
  localparam int WIDTH_BITS = 8;
  localparam int SLOPE_BITS = 16;
  localparam int LEN_FRAC   = (COORD_BITS > 16) ? 30 - COORD_BITS : 14;

  localparam int DW     = COORD_BITS + 1;          // segment delta, signed
  localparam int D2_W   = 2 * COORD_BITS + 2;      // dx^2 + dy^2
  localparam int RAD_W  = D2_W + 2 * LEN_FRAC;     // root radicand
  localparam int LQ_W   = RAD_W / 2;               // length, LEN_FRAC fraction bits
  localparam int NUM_W  = WIDTH_BITS + FRAC_BITS + LEN_FRAC + SLOPE_FRAC;
  localparam int DEN_W  = SLOPE_BITS + LQ_W;
  localparam int TH_W   = WIDTH_BITS + FRAC_BITS - 1;
  localparam int TA_W   = WIDTH_BITS + FRAC_BITS + SLOPE_FRAC;
  localparam int PA_W   = TA_W + 1 + DW;
  localparam int PT_W   = TH_W + 1 + DW;
  localparam int SB_W   = PA_W + 1;
  localparam int BX_W   = SB_W - FRAC_BITS;
  localparam int SW_W   = SB_W + 1;
  localparam int W_W    = SW_W - FRAC_BITS;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_SLOPE = CFG_IDX_W'(1);

  localparam logic [WIDTH_BITS-1:0] HEAD_WIDTH_RST = WIDTH_BITS'(10);
  localparam logic [SLOPE_BITS-1:0] HEAD_SLOPE_RST = SLOPE_BITS'(2365);

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         delta_t;

  typedef struct packed {
    coord_t ex;
    coord_t ey;
    delta_t dx;
    delta_t dy;
    logic   zero;
  } side_t;

endpackage

FILE: rtl/ah_if.sv
interface ah_in_if;
  import ah_pkg::*;
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface ah_out_if;
  import ah_pkg::*;
  logic   valid;
  logic   ready;
  coord_t base_x;
  coord_t base_y;
  coord_t left_x;
  coord_t left_y;
  coord_t right_x;
  coord_t right_y;
  logic   zero_length;
  logic   saturated;
  modport source (output valid, base_x, base_y, left_x, left_y, right_x, right_y,
                  zero_length, saturated, input ready);
  modport sink   (input valid, base_x, base_y, left_x, left_y, right_x, right_y,
                  zero_length, saturated, output ready);
endinterface

interface ah_cfg_if;
  import ah_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ah_sqrt.sv
module ah_sqrt
  import ah_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [D2_W-1:0]  d2_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [LQ_W-1:0]  root_o,
  output side_t            side_o
);

  // one result bit per stage, restoring digit-by-digit root
  logic [RAD_W-1:0]  rad_q  [LQ_W];
  logic [LQ_W+1:0]   rem_q  [LQ_W];
  logic [LQ_W-1:0]   root_q [LQ_W];
  side_t             side_q [LQ_W];
  logic              v_q    [LQ_W];

  for (genvar k = 0; k < LQ_W; k++) begin : g_stage
    logic [RAD_W-1:0] rad_in;
    logic [LQ_W+1:0]  rem_in;
    logic [LQ_W-1:0]  root_in;
    side_t            side_in;
    logic             v_in;
    logic [LQ_W+1:0]  rem_n;
    logic [LQ_W+1:0]  trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rad_in  = {d2_i, {(2*LEN_FRAC){1'b0}}};
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign rem_n = {rem_in[LQ_W-1:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (rem_n >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? rem_n - trial : rem_n;
        root_q[k] <= {root_in[LQ_W-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[LQ_W-1];
  assign root_o  = root_q[LQ_W-1];
  assign side_o  = side_q[LQ_W-1];

endmodule

FILE: rtl/ah_div.sv
module ah_div
  import ah_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_th_i,
  input  logic [DEN_W-1:0]  den_th_i,
  input  logic [NUM_W-1:0]  num_ta_i,
  input  logic [DEN_W-1:0]  den_ta_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  q_th_o,
  output logic [NUM_W-1:0]  q_ta_o,
  output side_t             side_o
);

  // two restoring dividers in lockstep, one quotient bit per stage
  logic [NUM_W-1:0] nth_q [NUM_W];
  logic [NUM_W-1:0] nta_q [NUM_W];
  logic [DEN_W-1:0] dth_q [NUM_W];
  logic [DEN_W-1:0] dta_q [NUM_W];
  logic [DEN_W:0]   rth_q [NUM_W];
  logic [DEN_W:0]   rta_q [NUM_W];
  logic [NUM_W-1:0] qth_q [NUM_W];
  logic [NUM_W-1:0] qta_q [NUM_W];
  side_t            side_q [NUM_W];
  logic             v_q    [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] nth_in, nta_in, qth_in, qta_in;
    logic [DEN_W-1:0] dth_in, dta_in;
    logic [DEN_W:0]   rth_in, rta_in, rth_n, rta_n;
    side_t            side_in;
    logic             v_in, ge_th, ge_ta;

    if (k == 0) begin : g_first
      assign nth_in  = num_th_i;
      assign nta_in  = num_ta_i;
      assign dth_in  = den_th_i;
      assign dta_in  = den_ta_i;
      assign rth_in  = '0;
      assign rta_in  = '0;
      assign qth_in  = '0;
      assign qta_in  = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign nth_in  = nth_q[k-1];
      assign nta_in  = nta_q[k-1];
      assign dth_in  = dth_q[k-1];
      assign dta_in  = dta_q[k-1];
      assign rth_in  = rth_q[k-1];
      assign rta_in  = rta_q[k-1];
      assign qth_in  = qth_q[k-1];
      assign qta_in  = qta_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign rth_n = {rth_in[DEN_W-1:0], nth_in[NUM_W-1]};
    assign rta_n = {rta_in[DEN_W-1:0], nta_in[NUM_W-1]};
    assign ge_th = (rth_n >= {1'b0, dth_in});
    assign ge_ta = (rta_n >= {1'b0, dta_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nth_q[k]  <= nth_in << 1;
        nta_q[k]  <= nta_in << 1;
        dth_q[k]  <= dth_in;
        dta_q[k]  <= dta_in;
        rth_q[k]  <= ge_th ? rth_n - {1'b0, dth_in} : rth_n;
        rta_q[k]  <= ge_ta ? rta_n - {1'b0, dta_in} : rta_n;
        qth_q[k]  <= {qth_in[NUM_W-2:0], ge_th};
        qta_q[k]  <= {qta_in[NUM_W-2:0], ge_ta};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NUM_W-1];
  assign q_th_o  = qth_q[NUM_W-1];
  assign q_ta_o  = qta_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

FILE: rtl/arrowhead_vertices.sv
// Arrowhead vertices: takes one segment (start, end) per transfer and returns the
// base point and the two wing points of an arrowhead whose tip is the end point,
// sized by head_width and head_slope. Fully pipelined: one segment per cycle while
// the output is not stalled. The pipe depth is set by the bit-per-stage square
// root (LQ_W stages) and the bit-per-stage dividers (NUM_W stages). The whole
// pipe stalls while the output holds an untaken result. Registers are to be written
// only while no segment is in flight; the user must ensure it, the block does not.
module arrowhead_vertices
  import ah_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  ah_cfg_if.sink    cfg_i,
  ah_in_if.sink     in_i,
  ah_out_if.source  out_o
);

  function automatic logic signed [BX_W-1:0] trunc_b(input logic signed [SB_W-1:0] v);
    logic signed [SB_W-1:0] t;
    t = v + (v[SB_W-1] ? SB_W'((1 << FRAC_BITS) - 1) : SB_W'(0));
    return t[SB_W-1:FRAC_BITS];
  endfunction

  function automatic logic signed [W_W-1:0] trunc_w(input logic signed [SW_W-1:0] v);
    logic signed [SW_W-1:0] t;
    t = v + (v[SW_W-1] ? SW_W'((1 << FRAC_BITS) - 1) : SW_W'(0));
    return t[SW_W-1:FRAC_BITS];
  endfunction

  function automatic logic [COORD_BITS:0] clamp(input logic signed [W_W-1:0] v);
    if (v > W_W'(COORD_MAX)) return {1'b1, COORD_MAX};
    if (v < W_W'(COORD_MIN)) return {1'b1, COORD_MIN};
    return {1'b0, v[COORD_BITS-1:0]};
  endfunction

  // configuration
  logic [WIDTH_BITS-1:0] width_q;
  logic [SLOPE_BITS-1:0] slope_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= HEAD_WIDTH_RST;
      slope_q <= HEAD_SLOPE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_HEAD_WIDTH: width_q <= cfg_i.data[WIDTH_BITS-1:0];
        REG_HEAD_SLOPE: slope_q <= cfg_i.data[SLOPE_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic v3_q;
  assign en         = !v3_q || out_o.ready;
  assign in_i.ready = en;

  // stage 0: deltas
  logic  v0_q;
  side_t s0_q;
  delta_t dx0, dy0;
  assign dx0 = DW'(in_i.end_x) - DW'(in_i.start_x);
  assign dy0 = DW'(in_i.end_y) - DW'(in_i.start_y);

  // stage 1: squared length
  logic            v1_q;
  side_t           s1_q;
  logic [D2_W-1:0] d2_q;
  logic [DW-1:0]   adx, ady;
  assign adx = s0_q.dx[DW-1] ? DW'(-s0_q.dx) : DW'(s0_q.dx);
  assign ady = s0_q.dy[DW-1] ? DW'(-s0_q.dy) : DW'(s0_q.dy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= '{ex: in_i.end_x, ey: in_i.end_y, dx: dx0, dy: dy0,
                zero: (dx0 == '0) && (dy0 == '0)};
      s1_q <= s0_q;
      d2_q <= D2_W'(adx) * D2_W'(adx) + D2_W'(ady) * D2_W'(ady);
    end
  end

  logic            vr;
  logic [LQ_W-1:0] lq;
  side_t           sr;

  ah_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .d2_i    (d2_q),
    .side_i  (s1_q),
    .valid_o (vr),
    .root_o  (lq),
    .side_o  (sr)
  );

  // divider operands
  logic                  vp_q;
  side_t                 sp_q;
  logic [NUM_W-1:0]      nth_q, nta_q;
  logic [DEN_W-1:0]      dth_q, dta_q;
  logic [SLOPE_BITS-1:0] slope_eff;
  assign slope_eff = (slope_q == '0) ? SLOPE_BITS'(1) : slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_q  <= sr;
      nth_q <= NUM_W'(width_q) << (FRAC_BITS + LEN_FRAC);
      nta_q <= NUM_W'(width_q) << (FRAC_BITS + LEN_FRAC + SLOPE_FRAC);
      dth_q <= DEN_W'({lq, 1'b0});
      dta_q <= DEN_W'(slope_eff) * DEN_W'(lq);
    end
  end

  logic             vd;
  logic [NUM_W-1:0] qth, qta;
  side_t            sd;

  ah_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (vp_q),
    .num_th_i (nth_q),
    .den_th_i (dth_q),
    .num_ta_i (nta_q),
    .den_ta_i (dta_q),
    .side_i   (sp_q),
    .valid_o  (vd),
    .q_th_o   (qth),
    .q_ta_o   (qta),
    .side_o   (sd)
  );

  // M1: products
  logic                    vm1_q;
  side_t                   sm1_q;
  logic signed [PA_W-1:0]  pax_q, pay_q;
  logic signed [PT_W-1:0]  ptx_q, pty_q;
  logic signed [TA_W:0]    ta_s;
  logic signed [TH_W:0]    th_s;
  assign ta_s = {1'b0, qta[TA_W-1:0]};
  assign th_s = {1'b0, qth[TH_W-1:0]};

  // M2: base point
  logic                    vm2_q;
  side_t                   sm2_q;
  logic signed [BX_W-1:0]  bx_q, by_q;
  logic signed [PT_W-1:0]  ptx2_q, pty2_q;
  logic signed [SB_W-1:0]  sbx, sby;
  assign sbx = (SB_W'(sm1_q.ex) <<< FRAC_BITS) - SB_W'(pax_q);
  assign sby = (SB_W'(sm1_q.ey) <<< FRAC_BITS) - SB_W'(pay_q);

  // M3: wings, clamp, output register
  logic signed [SW_W-1:0] bxs, bys;
  logic signed [W_W-1:0]  lx, ly, rx, ry;
  logic [COORD_BITS:0]    cbx, cby, clx, cly, crx, cry;
  assign bxs = SW_W'(bx_q) <<< FRAC_BITS;
  assign bys = SW_W'(by_q) <<< FRAC_BITS;
  assign lx  = trunc_w(bxs - SW_W'(pty2_q));
  assign ly  = trunc_w(bys + SW_W'(ptx2_q));
  assign rx  = trunc_w(bxs + SW_W'(pty2_q));
  assign ry  = trunc_w(bys - SW_W'(ptx2_q));
  assign cbx = clamp(W_W'(bx_q));
  assign cby = clamp(W_W'(by_q));
  assign clx = clamp(lx);
  assign cly = clamp(ly);
  assign crx = clamp(rx);
  assign cry = clamp(ry);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm1_q <= 1'b0;
      vm2_q <= 1'b0;
      v3_q  <= 1'b0;
    end else if (en) begin
      vm1_q <= vd;
      vm2_q <= vm1_q;
      v3_q  <= vm2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm1_q  <= sd;
      pax_q  <= PA_W'(ta_s) * PA_W'(sd.dx);
      pay_q  <= PA_W'(ta_s) * PA_W'(sd.dy);
      ptx_q  <= PT_W'(th_s) * PT_W'(sd.dx);
      pty_q  <= PT_W'(th_s) * PT_W'(sd.dy);
      sm2_q  <= sm1_q;
      bx_q   <= trunc_b(sbx);
      by_q   <= trunc_b(sby);
      ptx2_q <= ptx_q;
      pty2_q <= pty_q;
      if (sm2_q.zero) begin
        out_o.base_x      <= sm2_q.ex;
        out_o.base_y      <= sm2_q.ey;
        out_o.left_x      <= sm2_q.ex;
        out_o.left_y      <= sm2_q.ey;
        out_o.right_x     <= sm2_q.ex;
        out_o.right_y     <= sm2_q.ey;
        out_o.zero_length <= 1'b1;
        out_o.saturated   <= 1'b0;
      end else begin
        out_o.base_x      <= cbx[COORD_BITS-1:0];
        out_o.base_y      <= cby[COORD_BITS-1:0];
        out_o.left_x      <= clx[COORD_BITS-1:0];
        out_o.left_y      <= cly[COORD_BITS-1:0];
        out_o.right_x     <= crx[COORD_BITS-1:0];
        out_o.right_y     <= cry[COORD_BITS-1:0];
        out_o.zero_length <= 1'b0;
        out_o.saturated   <= cbx[COORD_BITS] | cby[COORD_BITS] | clx[COORD_BITS] |
                             cly[COORD_BITS] | crx[COORD_BITS] | cry[COORD_BITS];
      end
    end
  end

  assign out_o.valid = v3_q;

endmodule

FILE: rtl/ah_checker.sv
module ah_checker
  import ah_pkg::*;
(
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input coord_t base_x,
  input coord_t base_y,
  input coord_t left_x,
  input coord_t left_y,
  input coord_t right_x,
  input coord_t right_y,
  input logic   zero_length,
  input logic   saturated
);

  logic any_ext;
  assign any_ext = (base_x == COORD_MAX) || (base_x == COORD_MIN) ||
                   (base_y == COORD_MAX) || (base_y == COORD_MIN) ||
                   (left_x == COORD_MAX) || (left_x == COORD_MIN) ||
                   (left_y == COORD_MAX) || (left_y == COORD_MIN) ||
                   (right_x == COORD_MAX) || (right_x == COORD_MIN) ||
                   (right_y == COORD_MAX) || (right_y == COORD_MIN);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_zero_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && zero_length |-> !saturated)
    else $error("zero-length result flagged saturated");

  a_zero_pts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && zero_length |-> base_x == left_x && base_x == right_x &&
                                 base_y == left_y && base_y == right_y)
    else $error("zero-length vertices differ");

  a_sat_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && saturated |-> any_ext)
    else $error("saturated flag without a clamped coordinate");

endmodule

bind arrowhead_vertices ah_checker u_ah_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .base_x      (out_o.base_x),
  .base_y      (out_o.base_y),
  .left_x      (out_o.left_x),
  .left_y      (out_o.left_y),
  .right_x     (out_o.right_x),
  .right_y     (out_o.right_y),
  .zero_length (out_o.zero_length),
  .saturated   (out_o.saturated)
);
